// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/movdec_pkg.sv -----
// Types and constants shared by the MOV instruction byte decoder.
package movdec_pkg;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_MODRM,
    PH_TRAIL
  } phase_t;

  typedef enum logic [1:0] {
    FORM_REGREG,
    FORM_MEMORY,
    FORM_DIRECT,
    FORM_IMM
  } form_t;

  localparam logic [5:0] MOV_RM_OP  = 6'b100010;
  localparam logic [3:0] MOV_IMM_OP = 4'b1011;
  localparam logic [1:0] MOD_REG    = 2'b11;
  localparam logic [1:0] MOD_NODISP = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [2:0] RM_DIRECT  = 3'b110;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       trail;
    logic [7:0] opcode;
    logic [7:0] modrm;
    logic [7:0] low_byte;
    logic [7:0] last_byte;
  } raw_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    form_t       form;
    logic        word_size;
    logic        to_register;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [1:0]  disp_bytes;
    logic [15:0] displacement;
    logic [15:0] immediate;
  } rec_t;

endpackage

// ----- hdl/movdec_if.sv -----
// Channel interfaces of the MOV instruction byte decoder.
interface movdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_stream;

  modport source (output valid, output code_byte, output end_of_stream, input ready);
  modport sink (input valid, input code_byte, input end_of_stream, output ready);
endinterface

interface movdec_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  form;
  logic        word_size;
  logic        to_register;
  logic [2:0]  reg_field;
  logic [2:0]  rm_field;
  logic [1:0]  disp_bytes;
  logic [15:0] displacement;
  logic [15:0] immediate;

  modport source (
    output valid, output form, output word_size, output to_register,
    output reg_field, output rm_field, output disp_bytes,
    output displacement, output immediate, input ready
  );
  modport sink (
    input valid, input form, input word_size, input to_register,
    input reg_field, input rm_field, input disp_bytes,
    input displacement, input immediate, output ready
  );
endinterface

// ----- hdl/movdec_front.sv -----
// Byte sequencer that collects the bytes of one MOV instruction.
module movdec_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       code_byte,
  input  logic             end_of_stream,
  output logic             push,
  output movdec_pkg::raw_t raw
);
  import movdec_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic       two_left;
  logic       two_left_next;
  logic [7:0] opcode;
  logic [7:0] opcode_next;
  logic [7:0] modrm;
  logic [7:0] modrm_next;
  logic [7:0] low_byte;
  logic [7:0] low_byte_next;
  logic [1:0] mod_bits;
  logic [2:0] rm_bits;

  assign mod_bits = code_byte[7:6];
  assign rm_bits  = code_byte[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OPCODE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    two_left <= two_left_next;
    opcode   <= opcode_next;
    modrm    <= modrm_next;
    low_byte <= low_byte_next;
  end

  always_comb begin
    phase_next    = phase;
    two_left_next = two_left;
    opcode_next   = opcode;
    modrm_next    = modrm;
    low_byte_next = low_byte;
    push          = 1'b0;
    raw.trail     = (phase == PH_TRAIL);
    raw.opcode    = opcode;
    raw.modrm     = (phase == PH_MODRM) ? code_byte : modrm;
    raw.low_byte  = low_byte;
    raw.last_byte = code_byte;
    if (accept) begin
      case (phase)
        PH_MODRM: begin
          modrm_next = code_byte;
          if (mod_bits == MOD_REG || (mod_bits == MOD_NODISP && rm_bits != RM_DIRECT)) begin
            push       = 1'b1;
            phase_next = PH_OPCODE;
          end else begin
            two_left_next = (mod_bits != MOD_DISP8);
            phase_next    = PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          if (two_left) begin
            low_byte_next = code_byte;
            two_left_next = 1'b0;
          end else begin
            push       = 1'b1;
            phase_next = PH_OPCODE;
          end
        end
        default: begin
          if (code_byte[7:2] == MOV_RM_OP) begin
            opcode_next = code_byte;
            phase_next  = PH_MODRM;
          end else if (code_byte[7:4] == MOV_IMM_OP) begin
            opcode_next   = code_byte;
            two_left_next = code_byte[3];
            phase_next    = PH_TRAIL;
          end else begin
            phase_next = PH_OPCODE;
          end
        end
      endcase
      if (end_of_stream) begin
        phase_next = PH_OPCODE;
      end
    end
  end

endmodule

// ----- hdl/movdec_queue.sv -----
// Short queue of collected instructions between sequencer and decoder.
module movdec_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  movdec_pkg::raw_t        wr_data,
  input  logic                    pop,
  output movdec_pkg::raw_t        rd_data,
  output movdec_pkg::queue_stat_t stat
);
  import movdec_pkg::*;

  raw_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign rd_data        = slots[rd_ptr];
  assign stat.not_empty = (count != '0);
  assign stat.full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/movdec_back.sv -----
// Field decoder that turns a collected instruction into an output record.
module movdec_back (
  input  logic                    clk,
  input  logic                    rst,
  input  movdec_pkg::queue_stat_t stat,
  input  movdec_pkg::raw_t        head,
  output logic                    pop,
  movdec_out_if.source            decoded
);
  import movdec_pkg::*;

  rec_t       rec;
  rec_t       rec_next;
  logic       out_valid;
  logic [1:0] mod_bits;
  logic [2:0] rm_bits;
  logic       two;

  assign mod_bits = head.modrm[7:6];
  assign rm_bits  = head.modrm[2:0];
  assign two      = (mod_bits != MOD_DISP8);
  assign pop      = stat.not_empty && (!out_valid || decoded.ready);

  always_comb begin
    rec_next.form         = FORM_MEMORY;
    rec_next.word_size    = head.opcode[0];
    rec_next.to_register  = head.opcode[1];
    rec_next.reg_field    = head.modrm[5:3];
    rec_next.rm_field     = rm_bits;
    rec_next.disp_bytes   = 2'd0;
    rec_next.displacement = 16'h0000;
    rec_next.immediate    = 16'h0000;
    if (head.trail) begin
      if (head.opcode[7:4] == MOV_IMM_OP) begin
        rec_next.form        = FORM_IMM;
        rec_next.word_size   = head.opcode[3];
        rec_next.to_register = 1'b1;
        rec_next.reg_field   = head.opcode[2:0];
        rec_next.rm_field    = 3'd0;
        rec_next.immediate   = head.opcode[3] ? {head.last_byte, head.low_byte}
                                              : {8'h00, head.last_byte};
      end else begin
        rec_next.disp_bytes   = two ? 2'd2 : 2'd1;
        rec_next.displacement = two ? {head.last_byte, head.low_byte}
                                    : {8'h00, head.last_byte};
        if (mod_bits == MOD_NODISP && rm_bits == RM_DIRECT) begin
          rec_next.form = FORM_DIRECT;
        end
      end
    end else if (mod_bits == MOD_REG) begin
      rec_next.form = FORM_REGREG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (decoded.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec <= rec_next;
    end
  end

  assign decoded.valid        = out_valid;
  assign decoded.form         = rec.form;
  assign decoded.word_size    = rec.word_size;
  assign decoded.to_register  = rec.to_register;
  assign decoded.reg_field    = rec.reg_field;
  assign decoded.rm_field     = rec.rm_field;
  assign decoded.disp_bytes   = rec.disp_bytes;
  assign decoded.displacement = rec.displacement;
  assign decoded.immediate    = rec.immediate;

endmodule

// ----- hdl/mov_instruction_byte_decoder.sv -----
// Top level of the MOV instruction byte decoder.
//
// The code channel takes a 16-bit code stream one byte per request, with
// end_of_stream marking the final byte. Register/memory MOV and
// immediate-to-register MOV are recognized; every other opcode byte is
// skipped. The decoded channel delivers one record per completed instruction.
// A sequencer collects instruction bytes and pushes each complete instruction
// into a two-entry queue; a decoder pops it and fills the output register.
// Throughput is one byte per cycle while ready is high. A record passes
// through the queue and then the output register, which drives the decoded
// channel. When the receiver stalls, the output register and the queue keep
// taking bytes until two records wait in the queue; ready then drops until the
// receiver takes one. An end_of_stream byte drops any partial instruction.
// Synchronous reset empties the queue, clears the output valid flag and puts
// the sequencer back to expecting an opcode byte.
module mov_instruction_byte_decoder (
  input  logic         clk,
  input  logic         rst,
  movdec_in_if.sink    code,
  movdec_out_if.source decoded
);
  import movdec_pkg::*;

  logic        accept;
  logic        push;
  logic        pop;
  raw_t        raw;
  raw_t        head;
  queue_stat_t stat;

  assign code.ready = !stat.full || pop;
  assign accept     = code.valid && code.ready;

  movdec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .code_byte     (code.code_byte),
    .end_of_stream (code.end_of_stream),
    .push          (push),
    .raw           (raw)
  );

  movdec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (raw),
    .pop     (pop),
    .rd_data (head),
    .stat    (stat)
  );

  movdec_back u_back (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .head    (head),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

// ----- hdl/movdec_checker.sv -----
// Port checker for the MOV instruction byte decoder and its bind.
`include "assert_macros.svh"

module movdec_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  form,
  input logic        to_register,
  input logic [2:0]  rm_field,
  input logic [1:0]  disp_bytes,
  input logic [15:0] displacement,
  input logic [15:0] immediate
);
  import movdec_pkg::*;

  `ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "record shown after reset")
  `ASSERT_CLK(a_out_held, out_valid && !out_ready |=> out_valid, "stalled record dropped")
  `ASSERT_CLK(a_imm_form, out_valid && form == FORM_IMM |-> to_register && rm_field == 3'd0 && disp_bytes == 2'd0 && displacement == 16'h0000, "bad immediate record")
  `ASSERT_CLK(a_mem_form, out_valid && form != FORM_IMM |-> immediate == 16'h0000 && (form != FORM_DIRECT || disp_bytes == 2'd2) && (form != FORM_REGREG || disp_bytes == 2'd0) && (disp_bytes != 2'd0 || displacement == 16'h0000), "bad register or memory record")

endmodule

bind mov_instruction_byte_decoder movdec_checker u_movdec_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (decoded.valid),
  .out_ready    (decoded.ready),
  .form         (decoded.form),
  .to_register  (decoded.to_register),
  .rm_field     (decoded.rm_field),
  .disp_bytes   (decoded.disp_bytes),
  .displacement (decoded.displacement),
  .immediate    (decoded.immediate)
);
